// ===== rtl/core/esbs_pkg.sv =====
`timescale 1ns / 1ps

package esbs_pkg;

  // Field and register widths.
  localparam int SLIDE_W    = 12;
  localparam int HOLD_W     = 16;
  localparam int FRAME_W    = 8;
  localparam int HEIGHT_W   = 8;
  localparam int ELAPSED_W  = 16;
  localparam int SINCE_W    = 8;
  localparam int Y_W        = 9;
  localparam int OP_W       = 2;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Ease arithmetic widths: squares of a slide count, then times the height.
  localparam int SQ_W    = 2 * SLIDE_W;
  localparam int MUL_W   = SQ_W + SLIDE_W;
  localparam int NUMER_W = SQ_W + HEIGHT_W;
  localparam int ROWS_W  = HEIGHT_W;
  localparam int BIT_W   = $clog2(ROWS_W);

  // Register reset values.
  localparam logic [SLIDE_W-1:0]  SLIDE_RST  = SLIDE_W'(250);
  localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(4000);
  localparam logic [FRAME_W-1:0]  FRAME_RST  = FRAME_W'(16);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(60);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SHOW = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_IN   = 2'd1,
    PH_HOLD = 2'd2,
    PH_OUT  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                start;
    logic [SLIDE_W-1:0]  num;
    logic [SLIDE_W-1:0]  dur;
    logic [HEIGHT_W-1:0] height;
  } ease_req_t;

  typedef struct packed {
    logic              done;
    logic [ROWS_W-1:0] rows;
  } ease_rsp_t;

endpackage

// ===== rtl/core/esbs_if.sv =====
`timescale 1ns / 1ps

interface esbs_in_if;
  logic                      valid;
  logic                      ready;
  logic [esbs_pkg::OP_W-1:0] operation;
  logic                      text_present;

  modport source (output valid, operation, text_present, input ready);
  modport sink (input valid, operation, text_present, output ready);
endinterface

interface esbs_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [esbs_pkg::Y_W-1:0] y_position;
  logic                            frame_update;
  logic                            repaint_taken;
  logic [esbs_pkg::PHASE_W-1:0]    phase_now;

  modport source (output valid, y_position, frame_update, repaint_taken, phase_now,
                  input ready);
  modport sink (input valid, y_position, frame_update, repaint_taken, phase_now,
                output ready);
endinterface

interface esbs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [esbs_pkg::CFG_IDX_W-1:0]  index;
  logic [esbs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/esbs_ease_unit.sv =====
`timescale 1ns / 1ps

module esbs_ease_unit (
  input  logic                clk,
  input  logic                rst,
  input  esbs_pkg::ease_req_t req,
  output esbs_pkg::ease_rsp_t rsp
);
  import esbs_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE,
    E_SQ_NUM,
    E_SQ_DUR,
    E_MUL_H,
    E_DIV
  } ease_state_t;

  ease_state_t         state;
  logic [SLIDE_W-1:0]  num;
  logic [SLIDE_W-1:0]  dur;
  logic [HEIGHT_W-1:0] height;
  logic [SQ_W-1:0]     num_sq;
  logic [SQ_W-1:0]     den;
  logic [NUMER_W-1:0]  rem;
  logic [ROWS_W-1:0]   quo;
  logic [BIT_W-1:0]    bit_idx;

  logic [SQ_W-1:0]    mul_a;
  logic [SLIDE_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_p;
  logic [NUMER_W-1:0] trial;
  logic [NUMER_W:0]   diff;
  logic               fits;
  logic [ROWS_W-1:0]  quo_next;

  // One multiplier serves num squared, duration squared and the height scaling.
  always_comb begin
    unique case (state)
      E_SQ_NUM: begin
        mul_a = {{(SQ_W-SLIDE_W){1'b0}}, num};
        mul_b = num;
      end
      E_SQ_DUR: begin
        mul_a = {{(SQ_W-SLIDE_W){1'b0}}, dur};
        mul_b = dur;
      end
      E_MUL_H: begin
        mul_a = num_sq;
        mul_b = {{(SLIDE_W-HEIGHT_W){1'b0}}, height};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // Restoring division, one quotient bit per cycle, most significant first.
  // The quotient is below the height, so it fits in ROWS_W bits.
  always_comb begin
    trial    = {{(NUMER_W-SQ_W){1'b0}}, den} << bit_idx;
    diff     = {1'b0, rem} - {1'b0, trial};
    fits     = !diff[NUMER_W];
    quo_next = quo | (ROWS_W'(fits) << bit_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (req.start) begin
            num    <= req.num;
            dur    <= req.dur;
            height <= req.height;
            state  <= E_SQ_NUM;
          end
        end
        E_SQ_NUM: begin
          num_sq <= mul_p[SQ_W-1:0];
          state  <= E_SQ_DUR;
        end
        E_SQ_DUR: begin
          den   <= mul_p[SQ_W-1:0];
          state <= E_MUL_H;
        end
        E_MUL_H: begin
          rem     <= mul_p[NUMER_W-1:0];
          quo     <= '0;
          bit_idx <= BIT_W'(ROWS_W - 1);
          state   <= E_DIV;
        end
        E_DIV: begin
          if (fits) begin
            rem <= diff[NUMER_W-1:0];
          end
          quo <= quo_next;
          if (bit_idx == '0) begin
            rsp.done <= 1'b1;
            rsp.rows <= quo_next;
            state    <= E_IDLE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/eased_slide_banner_sequencer.sv =====
`timescale 1ns / 1ps

// Banner slide sequencer: each request is a millisecond tick, a show or a
// read-to-clear take of the repaint flag, and each gives exactly one result.
// A tick that moves the banner during slide in or slide out is eased: the
// shared ease unit makes three passes through one multiplier, then eight
// restoring division steps, before the result is pushed. Every other
// request goes straight to the push state, which waits until the output
// register is free. The block takes its next request on the cycle
// after the result enters the output register. One request is in flight at
// a time, and a new request is accepted while the previous result still
// waits in the output register.
module eased_slide_banner_sequencer (
  input logic       clk,
  input logic       rst,
  esbs_in_if.sink   in_ch,
  esbs_out_if.source out_ch,
  esbs_cfg_if.sink  cfg
);
  import esbs_pkg::*;

  typedef enum logic [1:0] {
    ST_READY,
    ST_CALC,
    ST_PUSH
  } ctl_state_t;

  ctl_state_t state;

  logic [SLIDE_W-1:0]  slide_dur;
  logic [HOLD_W-1:0]   hold_dur;
  logic [FRAME_W-1:0]  frame_int;
  logic [HEIGHT_W-1:0] height;

  phase_t                phase;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [SINCE_W-1:0]    since;
  logic                  forced;
  logic                  repaint;
  logic signed [Y_W-1:0] banner_y;

  logic res_frame;
  logic res_taken;

  ease_req_t ease_req;
  ease_rsp_t ease_rsp;

  logic                 in_fire;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [SINCE_W-1:0]   since_inc;
  logic                 frame_due;
  logic                 slide_done;
  logic                 hold_done;

  esbs_ease_unit u_ease (
    .clk (clk),
    .rst (rst),
    .req (ease_req),
    .rsp (ease_rsp)
  );

  assign in_ch.ready = (state == ST_READY);
  assign cfg.ready   = 1'b1;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
    since_inc   = (since == '1) ? since : since + 1'b1;
    frame_due   = forced || (since_inc >= frame_int);
    slide_done  = elapsed_inc >= {{(ELAPSED_W-SLIDE_W){1'b0}}, slide_dur};
    hold_done   = elapsed_inc >= hold_dur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_READY;
      slide_dur      <= SLIDE_RST;
      hold_dur       <= HOLD_RST;
      frame_int      <= FRAME_RST;
      height         <= HEIGHT_RST;
      phase          <= PH_IDLE;
      elapsed        <= '0;
      since          <= '0;
      forced         <= 1'b0;
      repaint        <= 1'b0;
      banner_y       <= '0;
      ease_req.start <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else begin
      ease_req.start <= 1'b0;

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_SLIDE:  slide_dur <= cfg.data[SLIDE_W-1:0];
          CFG_HOLD:   hold_dur  <= cfg.data[HOLD_W-1:0];
          CFG_FRAME:  frame_int <= cfg.data[FRAME_W-1:0];
          CFG_HEIGHT: height    <= cfg.data[HEIGHT_W-1:0];
        endcase
      end

      // A push in the same cycle refills the output register instead.
      if (out_ch.valid && out_ch.ready && state != ST_PUSH) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        ST_READY: begin
          if (in_fire) begin
            res_frame       <= 1'b0;
            res_taken       <= 1'b0;
            ease_req.dur    <= slide_dur;
            ease_req.height <= height;
            state           <= ST_PUSH;
            unique case (in_ch.operation)
              OP_TICK: begin
                if (phase != PH_IDLE) begin
                  elapsed <= elapsed_inc;
                  since   <= since_inc;
                  if (frame_due) begin
                    since  <= '0;
                    forced <= 1'b0;
                    unique case (phase)
                      PH_IN: begin
                        res_frame <= 1'b1;
                        if (slide_done) begin
                          phase    <= PH_HOLD;
                          elapsed  <= '0;
                          banner_y <= '0;
                        end else begin
                          // Ease-out measures the distance still to travel.
                          ease_req.start <= 1'b1;
                          ease_req.num   <= slide_dur - elapsed_inc[SLIDE_W-1:0];
                          state          <= ST_CALC;
                        end
                      end
                      PH_HOLD: begin
                        res_frame <= 1'b1;
                        banner_y  <= '0;
                        if (hold_done) begin
                          phase   <= PH_OUT;
                          elapsed <= '0;
                        end
                      end
                      PH_OUT: begin
                        if (slide_done) begin
                          // The last slide-out tick draws nothing.
                          phase   <= PH_IDLE;
                          repaint <= 1'b1;
                        end else begin
                          res_frame      <= 1'b1;
                          ease_req.start <= 1'b1;
                          ease_req.num   <= elapsed_inc[SLIDE_W-1:0];
                          state          <= ST_CALC;
                        end
                      end
                      default: ;
                    endcase
                  end
                end
              end
              OP_SHOW: begin
                if (in_ch.text_present) begin
                  phase    <= PH_IN;
                  elapsed  <= '0;
                  since    <= '0;
                  forced   <= 1'b1;
                  banner_y <= -$signed({1'b0, height});
                end
              end
              OP_TAKE: begin
                res_taken <= repaint;
                repaint   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CALC: begin
          if (ease_rsp.done) begin
            banner_y <= -$signed({1'b0, ease_rsp.rows});
            state    <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid         <= 1'b1;
            out_ch.y_position    <= banner_y;
            out_ch.frame_update  <= res_frame;
            out_ch.repaint_taken <= res_taken;
            out_ch.phase_now     <= phase;
            state                <= ST_READY;
          end
        end
        default: state <= ST_READY;
      endcase
    end
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    ease_rsp.done |-> state == ST_CALC)
    else $error("ease unit finished outside of a calculation");

  a_calc_in_slide: assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC |-> (phase == PH_IN || phase == PH_OUT))
    else $error("ease calculation running outside a slide phase");

  a_rows_below_height: assert property (@(posedge clk) disable iff (rst)
    ease_rsp.done |-> ease_rsp.rows < height)
    else $error("eased row count reached the banner height");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    (banner_y[Y_W-1] || banner_y == '0) && banner_y != {1'b1, {(Y_W-1){1'b0}}})
    else $error("banner position outside its range");

  a_frame_not_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_update |-> out_ch.phase_now != PH_IDLE)
    else $error("frame reported while idle");

  a_take_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.repaint_taken |-> !out_ch.frame_update)
    else $error("repaint take reported a frame");

endmodule

// ===== tb/eased_slide_banner_sequencer_tb.sv =====
`timescale 1ns / 1ps

module eased_slide_banner_sequencer_tb;
  import esbs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 275;

  typedef struct packed {
    logic [Y_W-1:0] y;
    logic           frame;
    logic           taken;
    phase_t         ph;
  } banner_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [OP_W-1:0]       op;
    logic                  text;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    banner_result_t        res;
  } stim_row_t;

  logic clk;
  logic rst;

  esbs_in_if  in_ch ();
  esbs_out_if out_ch ();
  esbs_cfg_if cfg_ch ();

  eased_slide_banner_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the sequencer registers and state.
  logic [SLIDE_W-1:0]   reg_slide;
  logic [HOLD_W-1:0]    reg_hold;
  logic [FRAME_W-1:0]   reg_frame;
  logic [HEIGHT_W-1:0]  reg_height;
  phase_t               ban_phase;
  logic [ELAPSED_W-1:0] ban_elapsed;
  logic [SINCE_W-1:0]   ban_since;
  logic                 ban_forced;
  logic                 ban_repaint;
  logic [Y_W-1:0]       ban_y;

  banner_result_t banner_results_due[$];
  stim_row_t      directed_rows[$];
  int unsigned    mismatch_count;
  int unsigned    result_count;
  bit             quiet;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [ROWS_W-1:0] eased_rows(input logic [HEIGHT_W-1:0] h,
                                                   input logic [SLIDE_W-1:0] num,
                                                   input logic [SLIDE_W-1:0] s);
    longint unsigned n;
    longint unsigned d;
    n = longint'(h) * longint'(num) * longint'(num);
    d = longint'(s) * longint'(s);
    return ROWS_W'(n / d);
  endfunction

  function automatic banner_result_t predict_banner_step(input logic [OP_W-1:0] op,
                                                         input logic text);
    banner_result_t r;
    logic [ELAPSED_W-1:0] e;
    r.frame = 1'b0;
    r.taken = 1'b0;
    case (op)
      OP_TICK: begin
        if (ban_phase != PH_IDLE) begin
          if (ban_elapsed != '1) ban_elapsed = ban_elapsed + 1'b1;
          if (ban_since != '1) ban_since = ban_since + 1'b1;
          if (ban_forced || ban_since >= reg_frame) begin
            ban_since = '0;
            ban_forced = 1'b0;
            e = ban_elapsed;
            case (ban_phase)
              PH_IN: begin
                if (e >= reg_slide) begin
                  ban_phase = PH_HOLD;
                  ban_elapsed = '0;
                  ban_y = '0;
                end else begin
                  ban_y = Y_W'(0) - {1'b0, eased_rows(reg_height, reg_slide - SLIDE_W'(e),
                                                      reg_slide)};
                end
                r.frame = 1'b1;
              end
              PH_HOLD: begin
                ban_y = '0;
                if (e >= reg_hold) begin
                  ban_phase = PH_OUT;
                  ban_elapsed = '0;
                end
                r.frame = 1'b1;
              end
              default: begin
                // The closing frame of slide out leaves y where it was.
                if (e >= reg_slide) begin
                  ban_phase = PH_IDLE;
                  ban_repaint = 1'b1;
                end else begin
                  ban_y = Y_W'(0) - {1'b0, eased_rows(reg_height, SLIDE_W'(e), reg_slide)};
                  r.frame = 1'b1;
                end
              end
            endcase
          end
        end
      end
      OP_SHOW: begin
        if (text) begin
          ban_phase = PH_IN;
          ban_elapsed = '0;
          ban_since = '0;
          ban_forced = 1'b1;
          ban_y = Y_W'(0) - {1'b0, reg_height};
        end
      end
      OP_TAKE: begin
        r.taken = ban_repaint;
        ban_repaint = 1'b0;
      end
      default: begin
      end
    endcase
    r.y = ban_y;
    r.ph = ban_phase;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void add_req(input logic [OP_W-1:0] op, input logic text);
    stim_row_t row;
    row = '{default: '0};
    row.op = op;
    row.text = text;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_req_typed(input logic [OP_W-1:0] op, input logic text,
                                        input int y, input logic frame,
                                        input logic taken, input phase_t ph);
    stim_row_t row;
    row = '{default: '0};
    row.op = op;
    row.text = text;
    row.typed = 1'b1;
    row.res.y = Y_W'(y);
    row.res.frame = frame;
    row.res.taken = taken;
    row.res.ph = ph;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = CFG_DATA_W'(data);
    directed_rows.push_back(row);
  endfunction

  // Lets every outstanding result arrive, then keeps waiting so that a
  // request with no visible effect has surely finished inside the block.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (banner_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SLIDE:  reg_slide = data[SLIDE_W-1:0];
      CFG_HOLD:   reg_hold = data[HOLD_W-1:0];
      CFG_FRAME:  reg_frame = data[FRAME_W-1:0];
      CFG_HEIGHT: reg_height = data[HEIGHT_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input int unsigned slide, input int unsigned hold,
                              input int unsigned frame, input int unsigned height);
    write_reg(CFG_SLIDE, CFG_DATA_W'(slide));
    write_reg(CFG_HOLD, CFG_DATA_W'(hold));
    write_reg(CFG_FRAME, CFG_DATA_W'(frame));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(height));
  endtask

  // A request that directly follows an accepted one keeps valid high, so the
  // valid line is only touched once per clock edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic text, input bit pause,
                              input bit typed, input banner_result_t typed_res);
    int unsigned gap;
    banner_result_t res;
    gap = draw_wait();
    if (gap > 0 || pause) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (pause) do @(posedge clk); while (banner_results_due.size() != 0);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.text_present <= text;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_banner_step(op, text);
    banner_results_due.push_back(typed ? typed_res : res);
  endtask

  // Result side: random stalls per result.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    banner_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_count <= result_count + 1;
      if (banner_results_due.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("result %0d: unexpected, got y=%0d frame=%0b taken=%0b phase=%0d",
                   result_count, $signed(out_ch.y_position), out_ch.frame_update,
                   out_ch.repaint_taken, out_ch.phase_now);
      end else begin
        want = banner_results_due.pop_front();
        if (out_ch.y_position !== want.y || out_ch.frame_update !== want.frame ||
            out_ch.repaint_taken !== want.taken || out_ch.phase_now !== want.ph) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $write("result %0d: expected y=%0d frame=%0b taken=%0b phase=%0d, ",
                   result_count, $signed(want.y), want.frame, want.taken, want.ph);
            $display("got y=%0d frame=%0b taken=%0b phase=%0d",
                     $signed(out_ch.y_position), out_ch.frame_update,
                     out_ch.repaint_taken, out_ch.phase_now);
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    int unsigned n;
    logic [OP_W-1:0] op;
    logic text;
    bit pause;
    stim_row_t row;

    rst = 1'b1;
    quiet = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.text_present <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SLIDE;
    cfg_ch.data <= '0;

    reg_slide = SLIDE_RST;
    reg_hold = HOLD_RST;
    reg_frame = FRAME_RST;
    reg_height = HEIGHT_RST;
    ban_phase = PH_IDLE;
    ban_elapsed = '0;
    ban_since = '0;
    ban_forced = 1'b0;
    ban_repaint = 1'b0;
    ban_y = '0;

    // Reset state, requests the block ignores, then a show and its first tick.
    add_req_typed(OP_TAKE, 1'b0, 0, 1'b0, 1'b0, PH_IDLE);
    add_req_typed(OP_TICK, 1'b1, 0, 1'b0, 1'b0, PH_IDLE);
    add_req_typed(OP_SHOW, 1'b0, 0, 1'b0, 1'b0, PH_IDLE);
    add_req_typed(OP_UNUSED, 1'b1, 0, 1'b0, 1'b0, PH_IDLE);
    add_req_typed(OP_SHOW, 1'b1, -60, 1'b0, 1'b0, PH_IN);
    add_req(OP_TICK, 1'b0);
    // Zero slide, frame interval, hold: one frame in slide in and hold, none out.
    add_cfg(CFG_SLIDE, 0);
    add_cfg(CFG_FRAME, 0);
    add_cfg(CFG_HEIGHT, 255);
    add_cfg(CFG_HOLD, 0);
    add_req_typed(OP_SHOW, 1'b1, -255, 1'b0, 1'b0, PH_IN);
    add_req_typed(OP_TICK, 1'b0, 0, 1'b1, 1'b0, PH_HOLD);
    add_req_typed(OP_TICK, 1'b0, 0, 1'b1, 1'b0, PH_OUT);
    add_req_typed(OP_TICK, 1'b0, 0, 1'b0, 1'b0, PH_IDLE);
    add_req_typed(OP_TAKE, 1'b0, 0, 1'b0, 1'b1, PH_IDLE);
    add_req_typed(OP_TAKE, 1'b1, 0, 1'b0, 1'b0, PH_IDLE);
    // Largest settings everywhere.
    add_cfg(CFG_SLIDE, 4095);
    add_cfg(CFG_HOLD, 65535);
    add_cfg(CFG_FRAME, 255);
    add_req_typed(OP_SHOW, 1'b1, -255, 1'b0, 1'b0, PH_IN);
    add_req(OP_TICK, 1'b1);
    add_req(OP_TICK, 1'b0);
    add_req(OP_SHOW, 1'b0);
    add_req_typed(OP_SHOW, 1'b1, -255, 1'b0, 1'b0, PH_IN);
    add_req(OP_UNUSED, 1'b0);
    // Smallest nonzero settings.
    add_cfg(CFG_SLIDE, 1);
    add_cfg(CFG_FRAME, 1);
    add_cfg(CFG_HEIGHT, 1);
    add_cfg(CFG_HOLD, 1);
    add_req(OP_SHOW, 1'b1);
    repeat (6) add_req(OP_TICK, 1'b0);
    add_req(OP_TAKE, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_reg(row.idx, row.data);
      else send_request(row.op, row.text, 1'b0, row.typed, row.res);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1)
        program_regs(48, 40, 5, 255);
      else
        program_regs($urandom_range(0, 12), $urandom_range(0, 24), $urandom_range(0, 3),
                     $urandom_range(1, 255));
      counted = 0;
      n = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 63) == 0) quiet = ~quiet;
        pick = $urandom_range(0, 99);
        text = 1'($urandom_range(0, 1));
        if (pick < 80) begin
          op = OP_TICK;
        end else if (pick < 84) begin
          op = OP_SHOW;
          text = 1'b1;
        end else if (pick < 87) begin
          op = OP_SHOW;
          text = 1'b0;
        end else if (pick < 96) begin
          op = OP_TAKE;
        end else begin
          op = OP_UNUSED;
        end
        pause = (n == 100) || ($urandom_range(0, 99) == 0);
        send_request(op, text, pause, 1'b0, '0);
        n++;
        counted++;
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== eased_slide_banner_sequencer.f =====
rtl/core/esbs_pkg.sv
rtl/core/esbs_if.sv
rtl/core/esbs_ease_unit.sv
rtl/core/eased_slide_banner_sequencer.sv
tb/eased_slide_banner_sequencer_tb.sv
